@@ src/gos_pkg.sv @@
package gos_pkg;

   // Fixed widths of the channel fields
   localparam int PORT_COORD_W = 12;
   localparam int THR_W        = 16;
   localparam int FRAC_BITS    = 15;
   localparam logic [THR_W-1:0] THR_RESET = 16'd16384;

   // Input word: one candidate rectangle
   typedef struct packed {
      logic [PORT_COORD_W-1:0] rect_x;
      logic [PORT_COORD_W-1:0] rect_y;
      logic [PORT_COORD_W-1:0] rect_width;
      logic [PORT_COORD_W-1:0] rect_height;
      logic                    last_in_list;
   } req_word_type;

   // Result word: verdict on the candidate
   typedef struct packed {
      logic                    kept;
      logic [PORT_COORD_W-1:0] out_x;
      logic [PORT_COORD_W-1:0] out_y;
      logic [PORT_COORD_W-1:0] out_width;
      logic [PORT_COORD_W-1:0] out_height;
      logic                    store_overflow;
      logic                    last_out;
   } rsp_word_type;

   // Compare pipeline status back to the sequencer
   typedef struct packed {
      logic busy;
      logic hit;
   } cmp_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DONE
   } gos_state_type;

endpackage

@@ src/gos_if.sv @@
interface gos_req_if;
   import gos_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface gos_rsp_if;
   import gos_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ src/greedy_overlap_suppression_top.sv @@
// Channel   Dir   Handshake          Word
// req_ch    in    valid/ready        rect_x, rect_y, rect_width, rect_height, last_in_list
// rsp_ch    out   valid/ready        kept, out_x, out_y, out_width, out_height,
//                                    store_overflow, last_out
// csr       in    csr_we (no ready)  csr_wdata = overlap_threshold
//
// A word is taken only after the verdict of the one before is loaded. It makes one store
// read per kept rectangle, then the five-stage compare pipeline drains before the verdict.
// With an empty store no read is issued.
// Reset is synchronous: it empties the store (count to zero) and sets the threshold to 0.5.
// A result held in the output register does not block the next request; while rsp_ch
// stalls, the word after it waits for its verdict and req_ch is held off.
module greedy_overlap_suppression_top #(
   parameter int MAX_KEPT   = 64,
   parameter int COORD_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   gos_req_if.sink                   req_ch,
   gos_rsp_if.source                 rsp_ch,
   input  logic                      csr_we,
   input  logic [gos_pkg::THR_W-1:0] csr_wdata
);
   import gos_pkg::*;

   localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CW = $clog2(MAX_KEPT + 1);
   localparam int RW = 4 * COORD_BITS;

   logic [THR_W-1:0] threshold_ff;
   logic             rd_en, wr_en;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic [RW-1:0]    cand, kept_rect;
   cmp_status_type   status;

   // Hold the threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THR_RESET;
      end else if (csr_we) begin
         threshold_ff <= csr_wdata;
      end
   end

   gos_ctrl #(
      .MAX_KEPT (MAX_KEPT),
      .CB       (COORD_BITS),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .cand    (cand),
      .status  (status)
   );

   gos_store #(
      .DEPTH (MAX_KEPT),
      .WIDTH (RW),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (kept_rect),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cand)
   );

   gos_cmp #(
      .CB (COORD_BITS)
   ) u_cmp (
      .clock     (clock),
      .reset     (reset),
      .issue     (rd_en),
      .cand      (cand),
      .kept_rect (kept_rect),
      .threshold (threshold_ff),
      .status    (status)
   );

endmodule

@@ src/gos_store.sv @@
module gos_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 48,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/gos_cmp.sv @@
module gos_cmp #(
   parameter int CB = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     issue,
   input  logic [4*CB-1:0]          cand,
   input  logic [4*CB-1:0]          kept_rect,
   input  logic [gos_pkg::THR_W-1:0] threshold,
   output gos_pkg::cmp_status_type  status
);
   import gos_pkg::*;

   localparam int AREA_W = 2 * CB;
   localparam int PROD_W = AREA_W + THR_W;

   logic [CB-1:0] cx, cy, cw, ch, kx, ky, kw, kh;
   logic [CB:0]   cx_end, cy_end, kx_end, ky_end, right, bottom, dx_full, dy_full;
   logic [CB-1:0] left, top;
   logic          dx_ok, dy_ok;

   logic              v0_ff;
   logic [AREA_W-1:0] cand_area_ff;
   logic              a_v_ff, a_ok_ff;
   logic [CB-1:0]     dx_ff, dy_ff;
   logic [AREA_W-1:0] karea_ff;
   logic              b_v_ff, b_ok_ff;
   logic [AREA_W-1:0] inter_b_ff, amin_ff, amin_in;
   logic              c_v_ff, c_ok_ff;
   logic [AREA_W-1:0] inter_c_ff;
   logic [PROD_W-1:0] prod_ff;
   logic              d_v_ff, hit_ff;
   logic [PROD_W-1:0] inter_scaled;

   assign {cx, cy, cw, ch} = cand;
   assign {kx, ky, kw, kh} = kept_rect;

   // Edges without wrap, intersection extents
   always_comb begin
      cx_end  = {1'b0, cx} + {1'b0, cw};
      cy_end  = {1'b0, cy} + {1'b0, ch};
      kx_end  = {1'b0, kx} + {1'b0, kw};
      ky_end  = {1'b0, ky} + {1'b0, kh};
      left    = (cx > kx) ? cx : kx;
      top     = (cy > ky) ? cy : ky;
      right   = (cx_end < kx_end) ? cx_end : kx_end;
      bottom  = (cy_end < ky_end) ? cy_end : ky_end;
      dx_ok   = right > {1'b0, left};
      dy_ok   = bottom > {1'b0, top};
      dx_full = right - {1'b0, left};
      dy_full = bottom - {1'b0, top};
   end

   assign amin_in = (cand_area_ff < karea_ff) ? cand_area_ff : karea_ff;
   assign inter_scaled = {1'b0, inter_c_ff, {FRAC_BITS{1'b0}}};

   // Candidate area, stable while a scan runs
   always_ff @(posedge clock) begin
      cand_area_ff <= {{CB{1'b0}}, cw} * {{CB{1'b0}}, ch};
   end

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff  <= 1'b0;
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else begin
         v0_ff  <= issue;
         a_v_ff <= v0_ff;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff;
      end
   end

   // Stage A: extents and kept area; B: intersection and smaller area;
   // C: threshold product; D: verdict
   always_ff @(posedge clock) begin
      a_ok_ff    <= dx_ok & dy_ok;
      dx_ff      <= dx_full[CB-1:0];
      dy_ff      <= dy_full[CB-1:0];
      karea_ff   <= {{CB{1'b0}}, kw} * {{CB{1'b0}}, kh};
      b_ok_ff    <= a_ok_ff;
      inter_b_ff <= {{CB{1'b0}}, dx_ff} * {{CB{1'b0}}, dy_ff};
      amin_ff    <= amin_in;
      c_ok_ff    <= b_ok_ff & (amin_ff != '0);
      inter_c_ff <= inter_b_ff;
      prod_ff    <= PROD_W'(threshold) * PROD_W'(amin_ff);
      hit_ff     <= c_ok_ff & (inter_scaled > prod_ff);
   end

   assign status.busy = v0_ff | a_v_ff | b_v_ff | c_v_ff | d_v_ff;
   assign status.hit  = d_v_ff & hit_ff;

endmodule

@@ src/gos_ctrl.sv @@
module gos_ctrl #(
   parameter int MAX_KEPT = 64,
   parameter int CB       = 12,
   parameter int AW       = 6,
   parameter int CW       = 7
) (
   input  logic                    clock,
   input  logic                    reset,
   gos_req_if.sink                 req,
   gos_rsp_if.source               rsp,
   output logic                    rd_en,
   output logic [AW-1:0]           rd_addr,
   output logic                    wr_en,
   output logic [AW-1:0]           wr_addr,
   output logic [4*CB-1:0]         cand,
   input  gos_pkg::cmp_status_type status
);
   import gos_pkg::*;

   localparam int XW = CB + PORT_COORD_W;

   gos_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, idx_ff, idx_in, idx_next;
   logic [4*CB-1:0] cand_ff, cand_in;
   logic          last_ff, last_in, hit_seen_ff, hit_seen_in;
   logic          rsp_valid_ff, rsp_valid_in, load_rsp, keep, has_room;
   rsp_word_type  rsp_data_ff, rsp_data_in;
   logic [XW-1:0] ext_x, ext_y, ext_w, ext_h, out_x_ext, out_y_ext, out_w_ext, out_h_ext;
   logic [CB-1:0] cx, cy, cw, ch;

   // Fit port coordinates to the internal width and back
   assign ext_x = XW'(req.data.rect_x);
   assign ext_y = XW'(req.data.rect_y);
   assign ext_w = XW'(req.data.rect_width);
   assign ext_h = XW'(req.data.rect_height);
   assign {cx, cy, cw, ch} = cand_ff;
   assign out_x_ext = XW'(cx);
   assign out_y_ext = XW'(cy);
   assign out_w_ext = XW'(cw);
   assign out_h_ext = XW'(ch);

   assign idx_next = CW'(idx_ff + CW'(1));
   assign has_room = count_ff < CW'(MAX_KEPT);
   assign keep     = !hit_seen_ff;
   assign load_rsp = (state_ff == S_DONE) && (!rsp_valid_ff || rsp.ready);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               state_in = (count_ff != '0) ? S_SCAN : S_DRAIN;
            end
         end
         S_SCAN: begin
            if (idx_next == count_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!status.busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs and datapath next values
   always_comb begin
      req.ready    = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      cand_in      = cand_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      hit_seen_in  = hit_seen_ff | status.hit;
      count_in     = count_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & !rsp.ready;
      case (state_ff)
         S_IDLE: begin
            req.ready   = 1'b1;
            cand_in     = {ext_x[CB-1:0], ext_y[CB-1:0], ext_w[CB-1:0], ext_h[CB-1:0]};
            last_in     = req.data.last_in_list;
            idx_in      = '0;
            hit_seen_in = 1'b0;
         end
         S_SCAN: begin
            rd_en  = 1'b1;
            idx_in = idx_next;
         end
         S_DRAIN: begin
         end
         S_DONE: begin
            if (load_rsp) begin
               wr_en                      = keep & has_room;
               rsp_valid_in               = 1'b1;
               rsp_data_in.kept           = keep;
               rsp_data_in.out_x          = out_x_ext[PORT_COORD_W-1:0];
               rsp_data_in.out_y          = out_y_ext[PORT_COORD_W-1:0];
               rsp_data_in.out_width      = out_w_ext[PORT_COORD_W-1:0];
               rsp_data_in.out_height     = out_h_ext[PORT_COORD_W-1:0];
               rsp_data_in.store_overflow = keep & !has_room;
               rsp_data_in.last_out       = last_ff;
               if (last_ff) begin
                  count_in = '0;
               end else if (keep & has_room) begin
                  count_in = CW'(count_ff + CW'(1));
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      hit_seen_ff <= hit_seen_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rd_addr   = idx_ff[AW-1:0];
   assign wr_addr   = count_ff[AW-1:0];
   assign cand      = cand_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_KEPT))
      else $error("kept count beyond store depth");

   a_read_below_count: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> idx_ff < count_ff)
      else $error("store read beyond kept count");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> has_room && !hit_seen_ff)
      else $error("store write without room or after a hit");

   a_overflow_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.store_overflow && !rsp_data_ff.kept))
      else $error("overflow flagged on a dropped rectangle");

   a_no_scan_while_busy_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |-> !status.busy)
      else $error("verdict taken while compares still in flight");

endmodule
